// ===== design/tkl_pkg.sv =====
// tkl_pkg: widths, fixed-point coefficient tables and segment selection
// for the type K thermocouple linearizer
// depends on nothing; imported by tkl_cj_fwd, tkl_inv, the top level and the testbench
package tkl_pkg;

  // powers of two and decimal scales used to build the coefficients
  localparam longint P15 = longint'(1) <<< 15;
  localparam longint P16 = longint'(1) <<< 16;
  localparam longint P20 = longint'(1) <<< 20;
  localparam longint P23 = longint'(1) <<< 23;
  localparam longint P26 = longint'(1) <<< 26;
  localparam longint P30 = longint'(1) <<< 30;
  localparam longint P31 = longint'(1) <<< 31;
  localparam longint P32 = longint'(1) <<< 32;
  localparam longint P35 = longint'(1) <<< 35;
  localparam longint P37 = longint'(1) <<< 37;
  localparam longint P44 = longint'(1) <<< 44;
  localparam longint E1  = 64'sd10;
  localparam longint E3  = 64'sd1000;
  localparam longint E4  = 64'sd10000;
  localparam longint E6  = 64'sd1000000;
  localparam longint E7  = 64'sd10000000;
  localparam longint E8  = 64'sd100000000;
  localparam longint E10 = 64'sd10000000000;
  localparam longint E11 = 64'sd100000000000;

  // inverse cubic coefficient scaling, truncating at each step
  function automatic longint inv_d3(input longint m);
    return ((((m * P32) / E7) * P23 / E7) * P15) / E7;
  endfunction

  function automatic longint inv_d2(input longint m);
    return ((((m * P35) / E6) * P20 / E6) * P15) / E3;
  endfunction

  function automatic longint inv_d1(input longint m);
    return (((m * P30) / E4) * P16) / E7;
  endfunction

  // port widths
  localparam int UW = 21;  // thermo voltage
  localparam int TW = 16;  // cold junction temperature
  localparam int OW = 18;  // hot junction temperature

  // forward (cold junction) cubic widths
  localparam int CJ_C3W = 31;
  localparam int CJ_C2W = 37;
  localparam int CJ_C1W = 56;
  localparam int CJ_C0W = 40;
  localparam int FP1W   = CJ_C3W + TW;
  localparam int FV1W   = ((FP1W > CJ_C2W) ? FP1W : CJ_C2W) + 1;
  localparam int FP2W   = FV1W + TW;
  localparam int FV2W   = ((FP2W > CJ_C1W) ? FP2W : CJ_C1W) + 1;
  localparam int FS2W   = FV2W - 20;
  localparam int FP3W   = FS2W + TW;
  localparam int FV3W   = ((FP3W > CJ_C0W) ? FP3W : CJ_C0W) + 1;
  localparam int FRW    = FV3W + 1;
  localparam int CJW    = FRW - 31;
  localparam int EXW    = ((UW > CJW) ? UW : CJW) + 1;

  // inverse cubic widths
  localparam int EW     = 21;
  localparam int ID3W   = 33;
  localparam int ID2W   = 50;
  localparam int ID1W   = 42;
  localparam int ID0W   = 45;
  localparam int IP1W   = ID3W + EW;
  localparam int IV1W   = ((IP1W > ID2W) ? IP1W : ID2W) + 1;
  localparam int IS1W   = IV1W - 24;
  localparam int IP2W   = IS1W + EW;
  localparam int IV2W   = ((IP2W > ID1W) ? IP2W : ID1W) + 1;
  localparam int IS2W   = IV2W - 20;
  localparam int IP3W   = IS2W + EW;
  localparam int IV3W   = ((IP3W > ID0W) ? IP3W : ID0W) + 1;
  localparam int IRW    = IV3W + 1;
  localparam int TMPW   = IRW - 20;

  // limits
  localparam longint CJ_B0     = -64'sd1280;
  localparam longint CJ_B1     = 64'sd0;
  localparam longint CJ_B2     = 64'sd7680;
  localparam longint E_MIN     = -64'sd61000;
  localparam longint E_MAX     = 64'sd530000;
  localparam longint T_OUT_MIN = -64'sd32768;
  localparam longint T_OUT_MAX = 64'sd131071;
  localparam longint CJ_RND    = P30;
  localparam longint T_RND     = longint'(1) <<< 19;

  // forward cubic, one entry per cold junction segment
  localparam longint CJ_C3 [4] = '{
    (-64'sd12080784 * P30) / E10,
    (64'sd645 * P30) / E3,
    (-64'sd55555556 * P30) / E11,
    (-64'sd95117845 * P30) / E11
  };
  localparam longint CJ_C2 [4] = '{
    (64'sd27021065 * P37) / E8,
    (64'sd392 * P37) / E3,
    (64'sd21785714 * P37) / E8,
    (64'sd21803752 * P37) / E8
  };
  localparam longint CJ_C1 [4] = '{
    (64'sd394254 * P44) / E3,
    (64'sd11045 * P44) / E1,
    (64'sd394925 * P44) / E3,
    (64'sd398584 * P44) / E3
  };
  localparam longint CJ_C0 [4] = '{
    (-64'sd7932 * P31) / E3,
    64'sd0,
    (-64'sd238 * P31) / E3,
    (-64'sd137121 * P31) / E3
  };

  // inverse cubic, one entry per voltage segment
  localparam longint INV_D3 [8] = '{
    inv_d3(64'sd1936205169), inv_d3(64'sd226548400), inv_d3(64'sd89977500),
    inv_d3(64'sd34964000), inv_d3(-64'sd14650700), inv_d3(64'sd2319300),
    inv_d3(64'sd1388900), inv_d3(64'sd1713500)
  };
  localparam longint INV_D2 [8] = '{
    inv_d2(64'sd216957856), inv_d2(64'sd3723747), inv_d2(-64'sd4328153),
    inv_d2(-64'sd3407548), inv_d2(64'sd3173305), inv_d2(-64'sd1530755),
    inv_d2(-64'sd656319), inv_d2(-64'sd1221224)
  };
  localparam longint INV_D1 [8] = '{
    inv_d1(64'sd1154688342), inv_d1(64'sd269060204), inv_d1(64'sd253297836),
    inv_d1(64'sd251976760), inv_d1(64'sd227264582), inv_d1(64'sd268254781),
    inv_d1(64'sd241381858), inv_d1(64'sd270060729)
  };
  localparam longint INV_D0 [8] = '{
    (64'sd123377116 * P26) / E6,
    (64'sd10330 * P26) / E4,
    (64'sd48 * P26) / E4,
    (64'sd1354 * P26) / E4,
    (64'sd19397 * P26) / E4,
    (-64'sd88764 * P26) / E4,
    (64'sd18259 * P26) / E3,
    (-64'sd26973 * P26) / E3
  };
  localparam longint INV_BOUND [7] = '{
    -64'sd35540, -64'sd19000, 64'sd12000, 64'sd61000,
    64'sd122000, 64'sd270000, 64'sd373000
  };

  // cold junction segment from the raw 1/128 degC count
  function automatic logic [1:0] cj_seg(input logic signed [TW-1:0] t);
    logic [1:0] s;
    if (t < CJ_B0) begin
      s = 2'd0;
    end else if (t < CJ_B1) begin
      s = 2'd1;
    end else if (t < CJ_B2) begin
      s = 2'd2;
    end else begin
      s = 2'd3;
    end
    return s;
  endfunction

  // voltage segment: number of boundaries at or below e
  function automatic logic [2:0] inv_seg(input logic signed [EW-1:0] e);
    logic [2:0] s;
    s = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (e >= INV_BOUND[i]) begin
        s = 3'(i + 1);
      end
    end
    return s;
  endfunction

endpackage

// ===== design/tkl_cj_fwd.sv =====
// tkl_cj_fwd: three pipeline stages of the cold junction cubic (Horner form)
// depends on tkl_pkg; enables come from the pipeline control in the top level
module tkl_cj_fwd
  import tkl_pkg::*;
(
  input  logic                   clk_i,
  input  logic [2:0]             en_i,
  input  logic signed [UW-1:0]   u_i,
  input  logic signed [TW-1:0]   t_i,
  input  logic                   fault_i,
  output logic signed [FV3W-1:0] v3_o,
  output logic signed [UW-1:0]   u_o,
  output logic                   fault_o
);

  logic signed [CJ_C3W-1:0] c3;
  logic signed [CJ_C2W-1:0] c2;
  logic signed [CJ_C1W-1:0] c1;
  logic signed [CJ_C0W-1:0] c0;
  logic [1:0]               seg0;
  logic signed [FP1W-1:0]   p1;
  logic signed [FV1W-1:0]   v1_d, v1_q;
  logic signed [FP2W-1:0]   p2;
  logic signed [FV2W-1:0]   v2_d, v2_q;
  logic signed [FS2W-1:0]   s2;
  logic signed [FP3W-1:0]   p3;
  logic signed [FV3W-1:0]   v3_d, v3_q;
  logic signed [TW-1:0]     t1_q, t2_q;
  logic [1:0]               seg1_q, seg2_q;
  logic signed [UW-1:0]     u1_q, u2_q, u3_q;
  logic                     f1_q, f2_q, f3_q;

  // stage 1: c3 * t + c2
  assign seg0 = cj_seg(t_i);
  assign c3   = CJ_C3W'(CJ_C3[seg0]);
  assign c2   = CJ_C2W'(CJ_C2[seg0]);
  assign p1   = c3 * t_i;
  assign v1_d = FV1W'(p1) + FV1W'(c2);

  // stage 2: v * t + c1
  assign c1   = CJ_C1W'(CJ_C1[seg1_q]);
  assign p2   = v1_q * t1_q;
  assign v2_d = FV2W'(p2) + FV2W'(c1);

  // stage 3: floor(v / 2^20) * t + c0
  assign c0   = CJ_C0W'(CJ_C0[seg2_q]);
  assign s2   = $signed(v2_q[FV2W-1:20]);
  assign p3   = s2 * t2_q;
  assign v3_d = FV3W'(p3) + FV3W'(c0);

  // stage registers, payload only
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      v1_q   <= v1_d;
      t1_q   <= t_i;
      seg1_q <= seg0;
      u1_q   <= u_i;
      f1_q   <= fault_i;
    end
    if (en_i[1]) begin
      v2_q   <= v2_d;
      t2_q   <= t1_q;
      seg2_q <= seg1_q;
      u2_q   <= u1_q;
      f2_q   <= f1_q;
    end
    if (en_i[2]) begin
      v3_q <= v3_d;
      u3_q <= u2_q;
      f3_q <= f2_q;
    end
  end

  assign v3_o    = v3_q;
  assign u_o     = u3_q;
  assign fault_o = f3_q;

endmodule

// ===== design/tkl_inv.sv =====
// tkl_inv: three pipeline stages of the inverse voltage-to-temperature cubic
// depends on tkl_pkg; enables come from the pipeline control in the top level
module tkl_inv
  import tkl_pkg::*;
(
  input  logic                   clk_i,
  input  logic [2:0]             en_i,
  input  logic signed [EW-1:0]   e_i,
  input  logic [2:0]             seg_i,
  input  logic                   bad_i,
  output logic signed [IV3W-1:0] w3_o,
  output logic                   bad_o
);

  logic signed [ID3W-1:0] d3;
  logic signed [ID2W-1:0] d2;
  logic signed [ID1W-1:0] d1;
  logic signed [ID0W-1:0] d0;
  logic signed [IP1W-1:0] p1;
  logic signed [IV1W-1:0] w1_d, w1_q;
  logic signed [IS1W-1:0] s1;
  logic signed [IP2W-1:0] p2;
  logic signed [IV2W-1:0] w2_d, w2_q;
  logic signed [IS2W-1:0] s2;
  logic signed [IP3W-1:0] p3;
  logic signed [IV3W-1:0] w3_d, w3_q;
  logic signed [EW-1:0]   e1_q, e2_q;
  logic [2:0]             seg1_q, seg2_q;
  logic                   b1_q, b2_q, b3_q;

  // stage 1: d3 * e + d2
  assign d3   = ID3W'(INV_D3[seg_i]);
  assign d2   = ID2W'(INV_D2[seg_i]);
  assign p1   = d3 * e_i;
  assign w1_d = IV1W'(p1) + IV1W'(d2);

  // stage 2: floor(v / 2^24) * e + d1
  assign d1   = ID1W'(INV_D1[seg1_q]);
  assign s1   = $signed(w1_q[IV1W-1:24]);
  assign p2   = s1 * e1_q;
  assign w2_d = IV2W'(p2) + IV2W'(d1);

  // stage 3: floor(v / 2^20) * e + d0
  assign d0   = ID0W'(INV_D0[seg2_q]);
  assign s2   = $signed(w2_q[IV2W-1:20]);
  assign p3   = s2 * e2_q;
  assign w3_d = IV3W'(p3) + IV3W'(d0);

  // stage registers, payload only
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      w1_q   <= w1_d;
      e1_q   <= e_i;
      seg1_q <= seg_i;
      b1_q   <= bad_i;
    end
    if (en_i[1]) begin
      w2_q   <= w2_d;
      e2_q   <= e1_q;
      seg2_q <= seg1_q;
      b2_q   <= b1_q;
    end
    if (en_i[2]) begin
      w3_q <= w3_d;
      b3_q <= b2_q;
    end
  end

  assign w3_o  = w3_q;
  assign bad_o = b3_q;

endmodule

// ===== design/thermocouple_k_linearizer.sv =====
// thermocouple_k_linearizer: top level, pipeline control, compensation and output stages
// depends on tkl_pkg, tkl_cj_fwd and tkl_inv
//
// Type K linearizer with cold junction compensation. One item goes in per cycle while
// stall_o is low, and one result comes out per item. Each item passes through eight
// stages before its result shows on valid_o: the three multiply-add steps of the cold
// junction cubic, the compensation add with range check, the three multiply-add steps
// of the inverse cubic, and the rounding and saturation stage that holds the result.
// Each stage holds one multiplier at most. Empty stages fill while the output is
// stalled, so stall_o rises only once all eight stages hold items. Nothing is kept
// between items.
module thermocouple_k_linearizer
  import tkl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic signed [UW-1:0] thermo_voltage_i,
  input  logic signed [TW-1:0] cold_junction_temp_i,
  input  logic                 cold_junction_fault_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic signed [OW-1:0] temperature_o,
  output logic                 error_o
);

  logic [8:1]              vld_q, vld_d;
  logic [8:1]              en;
  logic signed [FV3W-1:0]  v3;
  logic signed [UW-1:0]    u3;
  logic                    f3;
  logic signed [FRW-1:0]   cj_sum;
  logic signed [CJW-1:0]   cj;
  logic signed [EXW-1:0]   e_full;
  logic                    bad4_d;
  logic signed [EW-1:0]    e4_d, e4_q;
  logic [2:0]              seg4_d, seg4_q;
  logic                    bad4_q;
  logic signed [IV3W-1:0]  w3;
  logic                    bad7;
  logic signed [IRW-1:0]   t_sum;
  logic signed [TMPW-1:0]  t_full;
  logic signed [OW-1:0]    temp_d, temp_q;
  logic                    err_d, err_q;

  // stage enables: a stage moves when it is empty or the next one moves
  always_comb begin
    en[8] = !vld_q[8] || !stall_i;
    for (int k = 7; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign stall_o = !en[1];

  // valid bits travel with the items
  always_comb begin
    vld_d = vld_q;
    if (en[1]) begin
      vld_d[1] = valid_i;
    end
    for (int k = 2; k <= 8; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // cold junction cubic, stages 1 to 3
  tkl_cj_fwd u_cj_fwd (
    .clk_i   (clk_i),
    .en_i    (en[3:1]),
    .u_i     (thermo_voltage_i),
    .t_i     (cold_junction_temp_i),
    .fault_i (cold_junction_fault_i),
    .v3_o    (v3),
    .u_o     (u3),
    .fault_o (f3)
  );

  // stage 4: round the cold junction voltage, compensate, range check
  assign cj_sum = FRW'(v3) + FRW'(CJ_RND);
  assign cj     = $signed(cj_sum[FRW-1:31]);
  assign e_full = EXW'(u3) + EXW'(cj);
  assign bad4_d = f3 || (e_full < E_MIN) || (e_full > E_MAX);
  assign e4_d   = e_full[EW-1:0];
  assign seg4_d = inv_seg(e4_d);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      e4_q   <= e4_d;
      seg4_q <= seg4_d;
      bad4_q <= bad4_d;
    end
  end

  // inverse cubic, stages 5 to 7
  tkl_inv u_inv (
    .clk_i (clk_i),
    .en_i  (en[7:5]),
    .e_i   (e4_q),
    .seg_i (seg4_q),
    .bad_i (bad4_q),
    .w3_o  (w3),
    .bad_o (bad7)
  );

  // stage 8: round, saturate, zero the temperature on error
  assign t_sum  = IRW'(w3) + IRW'(T_RND);
  assign t_full = $signed(t_sum[IRW-1:20]);

  always_comb begin
    err_d = bad7;
    if (bad7) begin
      temp_d = '0;
    end else if (t_full < T_OUT_MIN) begin
      temp_d = OW'(T_OUT_MIN);
    end else if (t_full > T_OUT_MAX) begin
      temp_d = OW'(T_OUT_MAX);
    end else begin
      temp_d = t_full[OW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      temp_q <= temp_d;
      err_q  <= err_d;
    end
  end

  assign valid_o       = vld_q[8];
  assign temperature_o = temp_q;
  assign error_o       = err_q;

endmodule

// ===== design/tkl_checker.sv =====
// tkl_checker: port-level checks of the linearizer over time, and its bind
// depends on thermocouple_k_linearizer port list only
module tkl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [17:0] temperature_o,
  input logic        error_o
);

  // the block only pushes back when a result is waiting
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !stall_o)
    else $error("stall_o high with no result waiting");

  // an error result carries a zero temperature
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && error_o) |-> (temperature_o == 18'd0))
    else $error("error result with nonzero temperature");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(temperature_o) && $stable(error_o)))
    else $error("stalled result changed");

  // an unstalled output keeps the input side open
  a_no_stall_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!stall_i) |-> !stall_o)
    else $error("stall_o high while output drains");

endmodule

bind thermocouple_k_linearizer tkl_checker u_tkl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (valid_i),
  .stall_o       (stall_o),
  .valid_o       (valid_o),
  .stall_i       (stall_i),
  .temperature_o (temperature_o),
  .error_o       (error_o)
);

// ===== test/thermocouple_k_linearizer_test.sv =====
// thermocouple_k_linearizer_test: self-checking testbench for the type K linearizer
// depends on tkl_pkg and thermocouple_k_linearizer; a directed table followed by
// random items with bursty input, random output stall and an in-bench predictor
`timescale 1ns / 1ps

module thermocouple_k_linearizer_test;
  import tkl_pkg::*;

  localparam int NUM_RANDOM  = 1130;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic signed [UW-1:0] volt;
    logic signed [TW-1:0] cj_temp;
    logic                 fault;
    bit                   known;
    logic signed [OW-1:0] temp;
    logic                 err;
  } stim_row_t;

  typedef struct {
    logic signed [OW-1:0] temp;
    logic                 err;
  } temp_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 valid_i;
  logic                 stall_o;
  logic signed [UW-1:0] thermo_voltage_i;
  logic signed [TW-1:0] cold_junction_temp_i;
  logic                 cold_junction_fault_i;
  logic                 valid_o;
  logic                 stall_i;
  logic signed [OW-1:0] temperature_o;
  logic                 error_o;

  // coefficient tables of the predictor
  longint cj_coef [4][4];
  longint hot_coef [8][4];
  longint hot_bound [7];

  temp_result_t temp_queue [$];
  int  mismatches;
  int  idle_cycles;
  bit  send_done;
  bit  hold_request;
  bit  timed_out;

  thermocouple_k_linearizer dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .valid_i              (valid_i),
    .stall_o              (stall_o),
    .thermo_voltage_i     (thermo_voltage_i),
    .cold_junction_temp_i (cold_junction_temp_i),
    .cold_junction_fault_i(cold_junction_fault_i),
    .valid_o              (valid_o),
    .stall_i              (stall_i),
    .temperature_o        (temperature_o),
    .error_o              (error_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // fixed-point scaling with truncation at each divide
  function automatic longint fx_scale(input longint m, input int a, input longint p,
                                      input int b, input longint q, input int c,
                                      input longint r);
    longint v;
    v = (m * (longint'(1) <<< a)) / p;
    v = (v * (longint'(1) <<< b)) / q;
    v = (v * (longint'(1) <<< c)) / r;
    return v;
  endfunction

  function automatic void set_cj(input int s, input longint m3, input longint p3,
                                 input longint m2, input longint p2, input longint m1,
                                 input longint p1, input longint m0, input longint p0);
    cj_coef[s][0] = fx_scale(m3, 30, p3, 0, 1, 0, 1);
    cj_coef[s][1] = fx_scale(m2, 37, p2, 0, 1, 0, 1);
    cj_coef[s][2] = fx_scale(m1, 44, p1, 0, 1, 0, 1);
    cj_coef[s][3] = fx_scale(m0, 31, p0, 0, 1, 0, 1);
  endfunction

  function automatic void set_hot(input int s, input longint a3, input longint a2,
                                  input longint a1, input longint a0, input longint p0);
    hot_coef[s][0] = fx_scale(a3, 32, 10000000, 23, 10000000, 15, 10000000);
    hot_coef[s][1] = fx_scale(a2, 35, 1000000, 20, 1000000, 15, 1000);
    hot_coef[s][2] = fx_scale(a1, 30, 10000, 16, 10000000, 0, 1);
    hot_coef[s][3] = fx_scale(a0, 26, p0, 0, 1, 0, 1);
  endfunction

  // cold junction temperature to equivalent voltage, 0.1 uV
  function automatic longint cj_to_volt(input longint t);
    int     s;
    longint v;
    s = (t < -1280) ? 0 : (t < 0) ? 1 : (t < 7680) ? 2 : 3;
    v = cj_coef[s][0] * t + cj_coef[s][1];
    v = v * t + cj_coef[s][2];
    v = v >>> 20;
    v = v * t + cj_coef[s][3];
    return (v + (longint'(1) <<< 30)) >>> 31;
  endfunction

  // compensated voltage to hot junction temperature, 1/64 degC
  function automatic longint volt_to_temp(input longint e);
    int     s;
    longint v;
    s = 0;
    while (s < 7 && e >= hot_bound[s]) s++;
    v = hot_coef[s][0] * e + hot_coef[s][1];
    v = v >>> 24;
    v = v * e + hot_coef[s][2];
    v = v >>> 20;
    v = v * e + hot_coef[s][3];
    return (v + (longint'(1) <<< 19)) >>> 20;
  endfunction

  function automatic temp_result_t predict_temp(input logic signed [UW-1:0] volt,
                                                input logic signed [TW-1:0] cj_temp,
                                                input logic fault);
    temp_result_t r;
    longint       e;
    longint       t;
    r.temp = '0;
    r.err  = 1'b1;
    if (!fault) begin
      e = longint'(volt) + cj_to_volt(longint'(cj_temp));
      if (e >= -61000 && e <= 530000) begin
        t = volt_to_temp(e);
        if (t < -32768) t = -32768;
        if (t > 131071) t = 131071;
        r.temp = OW'(t);
        r.err  = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // acceptance on both channels, prediction and comparison
  always @(posedge clk_i) begin
    temp_result_t want;
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        temp_queue.push_back(predict_temp(thermo_voltage_i, cold_junction_temp_i,
                                          cold_junction_fault_i));
      end
      if (valid_o && !stall_i) begin
        if (temp_queue.size() == 0) begin
          report_mismatch("result with none expected", 1, 0);
        end else begin
          want = temp_queue.pop_front();
          if (error_o !== want.err) report_mismatch("error", error_o, want.err);
          if (temperature_o !== want.temp)
            report_mismatch("temperature", temperature_o, want.temp);
        end
      end
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    int run;
    stall_i = 1'b0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
        stall_i = 1'b0;
      end else begin
        if (run == 0) begin
          mode = $urandom_range(0, 3);
          run  = $urandom_range(5, 60);
        end
        run--;
        case (mode)
          0: stall_i = 1'b0;
          1: stall_i = ($urandom_range(0, 3) == 0);
          2: stall_i = ($urandom_range(0, 1) == 0);
          default: stall_i = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // offer one item and hold it until accepted
  task automatic send_item(input logic signed [UW-1:0] volt,
                           input logic signed [TW-1:0] cj_temp, input logic fault);
    bit taken;
    valid_i = 1'b1;
    thermo_voltage_i = volt;
    cold_junction_temp_i = cj_temp;
    cold_junction_fault_i = fault;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !stall_o;
      @(negedge clk_i);
    end
  endtask

  task automatic idle_gap(input int n);
    valid_i = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // stimulus
  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    temp_result_t r;
    int burst;
    int pick;
    logic signed [UW-1:0] volt;
    logic signed [TW-1:0] cj_temp;
    logic fault;

    valid_i = 1'b0;
    thermo_voltage_i = '0;
    cold_junction_temp_i = '0;
    cold_junction_fault_i = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    send_done = 1'b0;
    hold_request = 1'b0;
    timed_out = 1'b0;

    set_cj(0, -12080784, 64'sd10000000000, 27021065, 100000000, 394254, 1000, -7932, 1000);
    set_cj(1, 645, 1000, 392, 1000, 11045, 10, 0, 1);
    set_cj(2, -55555556, 64'sd100000000000, 21785714, 100000000, 394925, 1000, -238,
           1000);
    set_cj(3, -95117845, 64'sd100000000000, 21803752, 100000000, 398584, 1000, -137121,
           1000);
    set_hot(0, 1936205169, 216957856, 1154688342, 123377116, 1000000);
    set_hot(1, 226548400, 3723747, 269060204, 10330, 10000);
    set_hot(2, 89977500, -4328153, 253297836, 48, 10000);
    set_hot(3, 34964000, -3407548, 251976760, 1354, 10000);
    set_hot(4, -14650700, 3173305, 227264582, 19397, 10000);
    set_hot(5, 2319300, -1530755, 268254781, -88764, 10000);
    set_hot(6, 1388900, -656319, 241381858, 18259, 1000);
    set_hot(7, 1713500, -1221224, 270060729, -26973, 1000);
    hot_bound = '{-35540, -19000, 12000, 61000, 122000, 270000, 373000};

    // directed table: faults and out-of-range sums have fixed results
    rows.push_back('{21'sd1048575, 16'sd32767, 1'b1, 1'b1, 18'sd0, 1'b1});
    rows.push_back('{-21'sd1048576, -16'sd32768, 1'b1, 1'b1, 18'sd0, 1'b1});
    rows.push_back('{21'sd1048575, 16'sd0, 1'b0, 1'b1, 18'sd0, 1'b1});
    rows.push_back('{-21'sd1048576, 16'sd0, 1'b0, 1'b1, 18'sd0, 1'b1});
    rows.push_back('{21'sd0, 16'sd0, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{-21'sd61000, 16'sd0, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{21'sd530000, 16'sd0, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{-21'sd61001, 16'sd0, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{21'sd530001, 16'sd0, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{-21'sd35540, 16'sd0, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{-21'sd19000, 16'sd0, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{21'sd12000, 16'sd0, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{21'sd61000, 16'sd0, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{21'sd122000, 16'sd0, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{21'sd270000, 16'sd0, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{21'sd373000, 16'sd0, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{21'sd100000, -16'sd32768, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{21'sd100000, 16'sd32767, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{21'sd100000, -16'sd1281, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{21'sd100000, -16'sd1280, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{21'sd100000, -16'sd1, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{21'sd100000, 16'sd7679, 1'b0, 1'b0, 18'sd0, 1'b0});
    rows.push_back('{21'sd100000, 16'sd7680, 1'b0, 1'b0, 18'sd0, 1'b0});

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part, fixed results checked against the table as well
    foreach (rows[i]) begin
      row = rows[i];
      if (row.known) begin
        r = predict_temp(row.volt, row.cj_temp, row.fault);
        if (r.err !== row.err || r.temp !== row.temp)
          report_mismatch("directed row prediction", i, row.err);
      end
      send_item(row.volt, row.cj_temp, row.fault);
    end

    // random part in bursts
    burst = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 300) hold_request = 1'b1;
      if (n == 700) begin
        valid_i = 1'b0;
        while (temp_queue.size() != 0) @(negedge clk_i);
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
      end
      burst--;
      pick = $urandom_range(0, 9);
      fault = ($urandom_range(0, 9) == 0);
      if (pick < 7) begin
        // in-range voltage with a mostly ordinary cold junction
        volt = UW'($urandom_range(0, 591000)) - 21'sd61000;
        if ($urandom_range(0, 3) == 0) cj_temp = TW'($urandom);
        else cj_temp = TW'($urandom_range(0, 12000)) - 16'sd3000;
      end else begin
        volt = UW'($urandom);
        cj_temp = TW'($urandom);
      end
      send_item(volt, cj_temp, fault);
    end
    valid_i = 1'b0;
    send_done = 1'b1;
  end

  // watchdog and end of run
  initial begin
    wait (rst_ni === 1'b1);
    while (!(send_done && temp_queue.size() == 0) && !timed_out) begin
      @(negedge clk_i);
      if (idle_cycles >= IDLE_LIMIT) timed_out = 1'b1;
    end
    if (timed_out) begin
      $display("thermocouple_k_linearizer_test: FAIL");
    end else begin
      repeat (20) @(negedge clk_i);
      if (mismatches == 0) begin
        $display("thermocouple_k_linearizer_test: PASS");
      end else begin
        $display("thermocouple_k_linearizer_test: FAIL");
      end
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tkl_pkg.sv
design/tkl_cj_fwd.sv
design/tkl_inv.sv
design/thermocouple_k_linearizer.sv
design/tkl_checker.sv
test/thermocouple_k_linearizer_test.sv
